[hw/rtl/btpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the barometer compensation block: payload structs, register
// indexes and output limits. No dependencies.
package btpc_pkg;

  localparam int CFG_DW = 48;
  localparam int CFG_IW = 2;

  typedef enum logic [CFG_IW-1:0] {
    REG_TEMP_COEFFS    = 2'd0,
    REG_PRESS_COEFFS_A = 2'd1,
    REG_PRESS_COEFFS_B = 2'd2,
    REG_PRESS_COEFFS_C = 2'd3
  } cfg_reg_t;

  localparam int TEMP_MIN  = -5000;
  localparam int TEMP_MAX  = 10000;
  localparam int PRESS_MAX = 20000000;

  typedef struct packed {
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centideg;
    logic [24:0]        pressure_centipascal;
    logic               saturated_flag;
  } out_t;

endpackage

[hw/rtl/baro_temp_pressure_compensation_top.sv]
`timescale 1ns / 1ps
// Barometer temperature and pressure compensation, twelve-stage pipeline.
// Depends on btpc_pkg for payload structs, register indexes and limits.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word holding a raw
//   24-bit temperature and a raw 24-bit pressure conversion result.
//   Result channel (out_valid/out_ready/out_data) gives the temperature in
//   0.01 degC, the pressure in 0.01 Pa and a flag set when either was
//   clipped to its range.
//   Calibration words are written through cfg_we/cfg_index/cfg_data; the
//   user must do so only while the pipeline is empty; the block does not
//   enforce this. All four reset to zero. One word is taken every cycle
//   while in_ready is high; the twelve register stages each hold at most
//   one multiplier or one wide add, which sets the clock period, not the
//   rate. Every stage has its own valid bit and loads whenever it is empty
//   or the stage after it moves, so bubbles close up and the input keeps
//   flowing while a result waits. When the receiver holds out_ready low
//   the pipeline fills and then in_ready drops; nothing is lost.
//   Reset (rst_n low, synchronous) clears all valid bits and the
//   calibration registers.
module baro_temp_pressure_compensation_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  btpc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output btpc_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [btpc_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [btpc_pkg::CFG_DW-1:0]         cfg_data
);

  localparam int NS = 12;
  localparam int PW = 52;

  logic [39:0] temp_coeffs_r;
  logic [47:0] press_a_r;
  logic [47:0] press_b_r;
  logic [31:0] press_c_r;

  logic [NS:1] vld_r;
  logic [NS:1] rdy;

  // Decoded calibration.
  logic [15:0]        t1;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3;
  logic signed [16:0] p1m, p2m, p6s;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p9;
  logic signed [PW-1:0] a_term;

  // Stage registers.
  logic signed [25:0] d_s1_r;
  logic signed [24:0] u_s1_r;

  logic signed [42:0] dt2_s2_r;
  logic signed [51:0] dd_s2_r;
  logic signed [37:0] e_s2_r;
  logic signed [41:0] up2_s2_r;
  logic signed [32:0] up3_s2_r, up4_s2_r, up11_s2_r;
  logic signed [49:0] uu_s2_r;

  logic signed [60:0] tna_s3_r;
  logic signed [59:0] ddt3_s3_r;
  logic signed [37:0] e_s3_r;
  logic signed [33:0] i_s3_r;
  logic signed [57:0] uup10_s3_r;
  logic signed [58:0] kl_s3_r;
  logic signed [57:0] kh_s3_r;
  logic signed [41:0] up2_s3_r;
  logic signed [32:0] up3_s3_r, up4_s3_r;

  logic signed [29:0] t_s4_r;
  logic signed [34:0] k_s4_r;
  logic signed [37:0] e_s4_r;
  logic signed [33:0] i_s4_r;
  logic signed [57:0] uup10_s4_r;
  logic signed [41:0] up2_s4_r;
  logic signed [32:0] up3_s4_r, up4_s4_r;

  logic signed [59:0] tsq_s5_r;
  logic signed [40:0] b_s5_r;
  logic signed [51:0] fl_s5_r;
  logic signed [50:0] fh_s5_r;
  logic signed [59:0] jl_s5_r;
  logic signed [58:0] jh_s5_r;
  logic signed [21:0] tc_s5_r;
  logic signed [29:0] t_s5_r;
  logic signed [37:0] e_s5_r;
  logic signed [33:0] i_s5_r;
  logic signed [34:0] k_s5_r;
  logic signed [32:0] up3_s5_r, up4_s5_r;

  logic signed [60:0] cl_s6_r;
  logic signed [59:0] ch_s6_r;
  logic signed [43:0] c_s6_r;
  logic signed [63:0] gl_s6_r;
  logic signed [62:0] gh_s6_r;
  logic signed [40:0] j_s6_r;
  logic signed [42:0] f_s6_r;
  logic signed [PW-1:0] sa_s6_r, sb_s6_r;
  logic signed [21:0] tc_s6_r;
  logic signed [32:0] up4_s6_r;

  logic signed [61:0] tcube_s7_r;
  logic signed [45:0] g_s7_r;
  logic signed [42:0] f_s7_r;
  logic signed [PW-1:0] sum_s7_r;
  logic signed [21:0] tc_s7_r;
  logic signed [32:0] up4_s7_r;

  logic signed [46:0] d_s8_r;
  logic signed [63:0] hl_s8_r;
  logic signed [64:0] hh_s8_r;
  logic signed [PW-1:0] sum_s8_r;
  logic signed [21:0] tc_s8_r;

  logic signed [50:0] h_s9_r;
  logic signed [PW-1:0] sum_s9_r;
  logic signed [21:0] tc_s9_r;

  logic signed [PW-1:0] p_s10_r;
  logic signed [21:0] tc_s10_r;

  logic signed [PW-9:0] pc_s11_r;
  logic signed [21:0] tc_s11_r;

  btpc_pkg::out_t out_r;

  // Full-width products and shift-add combinations.
  logic signed [41:0] e_full;
  logic signed [65:0] i_full;
  logic signed [61:0] tnum;
  logic signed [83:0] k_full;
  logic signed [46:0] b_full;
  logic signed [71:0] f_full;
  logic signed [37:0] tcn_full;
  logic signed [67:0] c_full;
  logic signed [88:0] j_full;
  logic signed [90:0] tcube_full;
  logic signed [93:0] g_full;
  logic signed [69:0] d_full;
  logic signed [95:0] h_full;
  logic signed [PW+7:0] pcn_full;

  logic sat_t, sat_p;

  always_comb begin
    t1     = temp_coeffs_r[15:0];
    t2s    = $signed({1'b0, temp_coeffs_r[31:16]});
    t3     = $signed(temp_coeffs_r[39:32]);
    p1m    = 17'($signed(press_a_r[15:0])) - 17'sd16384;
    p2m    = 17'($signed(press_a_r[31:16])) - 17'sd16384;
    p3     = $signed(press_a_r[39:32]);
    p4     = $signed(press_a_r[47:40]);
    p6s    = $signed({1'b0, press_b_r[31:16]});
    p7     = $signed(press_b_r[39:32]);
    p8     = $signed(press_b_r[47:40]);
    p9     = $signed(press_c_r[15:0]);
    p10    = $signed(press_c_r[23:16]);
    p11    = $signed(press_c_r[31:24]);
    a_term = PW'($signed({1'b0, press_b_r[15:0], 19'b0}));
  end

  always_comb begin
    e_full     = 42'(u_s1_r) * 42'(p1m);
    i_full     = 66'(uu_s2_r) * 66'(p9);
    tnum       = 62'(tna_s3_r) + 62'(ddt3_s3_r) + 62'sd2147483648;
    k_full     = (84'(kh_s3_r) <<< 25) + 84'(kl_s3_r);
    b_full     = 47'(p6s) * 47'(t_s4_r);
    f_full     = (72'(fh_s5_r) <<< 21) + 72'(fl_s5_r);
    tcn_full   = 38'(t_s4_r) * 38'sd100 + 38'sd32768;
    c_full     = 68'(p7) * 68'(tsq_s5_r);
    j_full     = (89'(jh_s5_r) <<< 29) + 89'(jl_s5_r);
    tcube_full = (91'(ch_s6_r) <<< 30) + 91'(cl_s6_r);
    g_full     = (94'(gh_s6_r) <<< 30) + 94'(gl_s6_r);
    d_full     = 70'(p8) * 70'(tcube_s7_r);
    h_full     = (96'(hh_s8_r) <<< 30) + 96'(hl_s8_r);
    pcn_full   = (PW+8)'(p_s10_r) * (PW+8)'(100) + (PW+8)'(32768);
  end

  always_comb begin
    sat_t = (tc_s11_r < 22'(btpc_pkg::TEMP_MIN)) || (tc_s11_r > 22'(btpc_pkg::TEMP_MAX));
    sat_p = (pc_s11_r < 0) || (pc_s11_r > (PW-8)'(btpc_pkg::PRESS_MAX));
  end

  // A stage loads when it is empty or its successor moves.
  always_comb begin
    rdy[NS] = !vld_r[NS] || out_ready;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld_r[NS];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r         <= '0;
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (cfg_we) begin
        case (btpc_pkg::cfg_reg_t'(cfg_index))
          btpc_pkg::REG_TEMP_COEFFS:    temp_coeffs_r <= cfg_data[39:0];
          btpc_pkg::REG_PRESS_COEFFS_A: press_a_r     <= cfg_data[47:0];
          btpc_pkg::REG_PRESS_COEFFS_B: press_b_r     <= cfg_data[47:0];
          btpc_pkg::REG_PRESS_COEFFS_C: press_c_r     <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d_s1_r <= $signed({2'b0, in_data.raw_temperature}) - $signed({2'b0, t1, 8'h00});
      u_s1_r <= $signed({1'b0, in_data.raw_pressure});
    end
    if (rdy[2]) begin
      dt2_s2_r  <= 43'(d_s1_r) * 43'(t2s);
      dd_s2_r   <= 52'(d_s1_r) * 52'(d_s1_r);
      e_s2_r    <= e_full[41:4];
      up2_s2_r  <= 42'(u_s1_r) * 42'(p2m);
      up3_s2_r  <= 33'(u_s1_r) * 33'(p3);
      up4_s2_r  <= 33'(u_s1_r) * 33'(p4);
      up11_s2_r <= 33'(u_s1_r) * 33'(p11);
      uu_s2_r   <= 50'(u_s1_r) * 50'(u_s1_r);
    end
    if (rdy[3]) begin
      tna_s3_r   <= 61'(dt2_s2_r) <<< 18;
      ddt3_s3_r  <= 60'(dd_s2_r) * 60'(t3);
      e_s3_r     <= e_s2_r;
      i_s3_r     <= i_full[65:32];
      uup10_s3_r <= 58'(uu_s2_r) * 58'(p10);
      kl_s3_r    <= 59'($signed({1'b0, uu_s2_r[24:0]})) * 59'(up11_s2_r);
      kh_s3_r    <= 58'($signed(uu_s2_r[49:25])) * 58'(up11_s2_r);
      up2_s3_r   <= up2_s2_r;
      up3_s3_r   <= up3_s2_r;
      up4_s3_r   <= up4_s2_r;
    end
    if (rdy[4]) begin
      t_s4_r     <= tnum[61:32];
      k_s4_r     <= k_full[83:49];
      e_s4_r     <= e_s3_r;
      i_s4_r     <= i_s3_r;
      uup10_s4_r <= uup10_s3_r;
      up2_s4_r   <= up2_s3_r;
      up3_s4_r   <= up3_s3_r;
      up4_s4_r   <= up4_s3_r;
    end
    if (rdy[5]) begin
      tsq_s5_r <= 60'(t_s4_r) * 60'(t_s4_r);
      b_s5_r   <= b_full[46:6];
      // The pressure-times-temperature product is split into two halves.
      fl_s5_r  <= 52'($signed({1'b0, up2_s4_r[20:0]})) * 52'(t_s4_r);
      fh_s5_r  <= 51'($signed(up2_s4_r[41:21])) * 51'(t_s4_r);
      jl_s5_r  <= 60'($signed({1'b0, uup10_s4_r[28:0]})) * 60'(t_s4_r);
      jh_s5_r  <= 59'($signed(uup10_s4_r[57:29])) * 59'(t_s4_r);
      tc_s5_r  <= tcn_full[37:16];
      t_s5_r   <= t_s4_r;
      e_s5_r   <= e_s4_r;
      i_s5_r   <= i_s4_r;
      k_s5_r   <= k_s4_r;
      up3_s5_r <= up3_s4_r;
      up4_s5_r <= up4_s4_r;
    end
    if (rdy[6]) begin
      cl_s6_r  <= 61'($signed({1'b0, tsq_s5_r[29:0]})) * 61'(t_s5_r);
      ch_s6_r  <= 60'($signed(tsq_s5_r[59:30])) * 60'(t_s5_r);
      c_s6_r   <= c_full[67:24];
      gl_s6_r  <= 64'($signed({1'b0, tsq_s5_r[29:0]})) * 64'(up3_s5_r);
      gh_s6_r  <= 63'($signed(tsq_s5_r[59:30])) * 63'(up3_s5_r);
      j_s6_r   <= j_full[88:48];
      f_s6_r   <= f_full[71:29];
      sa_s6_r  <= a_term + PW'(b_s5_r) + PW'(e_s5_r);
      sb_s6_r  <= PW'(i_s5_r) + PW'(k_s5_r);
      tc_s6_r  <= tc_s5_r;
      up4_s6_r <= up4_s5_r;
    end
    if (rdy[7]) begin
      tcube_s7_r <= tcube_full[85:24];
      g_s7_r     <= g_full[93:48];
      f_s7_r     <= f_s6_r;
      sum_s7_r   <= sa_s6_r + sb_s6_r + PW'(c_s6_r) + PW'(j_s6_r);
      tc_s7_r    <= tc_s6_r;
      up4_s7_r   <= up4_s6_r;
    end
    if (rdy[8]) begin
      d_s8_r   <= d_full[69:23];
      hl_s8_r  <= 64'($signed({1'b0, tcube_s7_r[29:0]})) * 64'(up4_s7_r);
      hh_s8_r  <= 65'($signed(tcube_s7_r[61:30])) * 65'(up4_s7_r);
      sum_s8_r <= sum_s7_r + PW'(g_s7_r) + PW'(f_s7_r);
      tc_s8_r  <= tc_s7_r;
    end
    if (rdy[9]) begin
      h_s9_r   <= h_full[95:45];
      sum_s9_r <= sum_s8_r + PW'(d_s8_r);
      tc_s9_r  <= tc_s8_r;
    end
    if (rdy[10]) begin
      p_s10_r  <= sum_s9_r + PW'(h_s9_r);
      tc_s10_r <= tc_s9_r;
    end
    if (rdy[11]) begin
      pc_s11_r <= pcn_full[PW+7:16];
      tc_s11_r <= tc_s10_r;
    end
    if (rdy[12]) begin
      out_r.saturated_flag <= sat_t || sat_p;
      if (tc_s11_r < 22'(btpc_pkg::TEMP_MIN)) begin
        out_r.temperature_centideg <= 15'(btpc_pkg::TEMP_MIN);
      end else if (tc_s11_r > 22'(btpc_pkg::TEMP_MAX)) begin
        out_r.temperature_centideg <= 15'(btpc_pkg::TEMP_MAX);
      end else begin
        out_r.temperature_centideg <= tc_s11_r[14:0];
      end
      if (pc_s11_r < 0) begin
        out_r.pressure_centipascal <= '0;
      end else if (pc_s11_r > (PW-8)'(btpc_pkg::PRESS_MAX)) begin
        out_r.pressure_centipascal <= 25'(btpc_pkg::PRESS_MAX);
      end else begin
        out_r.pressure_centipascal <= pc_s11_r[24:0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.temperature_centideg >= 15'(btpc_pkg::TEMP_MIN) &&
                   out_data.temperature_centideg <= 15'(btpc_pkg::TEMP_MAX)))
    else $error("temperature result outside its range");
  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pressure_centipascal <= 25'(btpc_pkg::PRESS_MAX)))
    else $error("pressure result outside its range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r && !out_ready))
    else $error("input stalled while the pipeline has a free stage");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("valid bits not cleared by reset");
`endif

endmodule

[tb/sv/baro_temp_pressure_compensation_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the barometer compensation pipeline: random and
// directed words across calibration phases, each result checked in order.
// Depends on btpc_pkg and baro_temp_pressure_compensation_top.
module baro_temp_pressure_compensation_top_tb;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  btpc_pkg::in_t in_data;
  btpc_pkg::out_t out_data;
  logic cfg_we;
  logic [btpc_pkg::CFG_IW-1:0] cfg_index;
  logic [btpc_pkg::CFG_DW-1:0] cfg_data;

  logic [39:0] temp_cal;
  logic [47:0] press_cal_a, press_cal_b;
  logic [31:0] press_cal_c;

  btpc_pkg::in_t  raw_words[$];
  btpc_pkg::out_t expected_readings[$];
  int   error_count;
  int   send_idle_pct, recv_stall_pct;

  baro_temp_pressure_compensation_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of a*b / 2^s over the full 128-bit product, kept to 64 bits.
  function automatic longint mul_floor(longint a, longint b, int s);
    logic signed [127:0] wa, wb, pr;
    wa = a;
    wb = b;
    pr = (wa * wb) >>> s;
    return pr[63:0];
  endfunction

  function automatic longint centi_round(longint q16);
    return (q16 * 100 + 64'sd32768) >>> 16;
  endfunction

  function automatic btpc_pkg::out_t compensate(btpc_pkg::in_t w);
    longint ut, u, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint d, tnum, t, tsq, tcube, uu, p, tc, pc;
    logic sat;
    btpc_pkg::out_t r;
    ut  = longint'(w.raw_temperature);
    u   = longint'(w.raw_pressure);
    t1  = longint'(temp_cal[15:0]);
    t2  = longint'(temp_cal[31:16]);
    t3  = longint'($signed(temp_cal[39:32]));
    p1  = longint'($signed(press_cal_a[15:0])) - 16384;
    p2  = longint'($signed(press_cal_a[31:16])) - 16384;
    p3  = longint'($signed(press_cal_a[39:32]));
    p4  = longint'($signed(press_cal_a[47:40]));
    p5  = longint'(press_cal_b[15:0]);
    p6  = longint'(press_cal_b[31:16]);
    p7  = longint'($signed(press_cal_b[39:32]));
    p8  = longint'($signed(press_cal_b[47:40]));
    p9  = longint'($signed(press_cal_c[15:0]));
    p10 = longint'($signed(press_cal_c[23:16]));
    p11 = longint'($signed(press_cal_c[31:24]));
    d = ut - t1 * 256;
    tnum = d * t2 * 262144 + d * d * t3;
    t = (tnum + 64'sd2147483648) >>> 32;
    tsq = t * t;
    tcube = mul_floor(tsq, t, 24);
    uu = u * u;
    p = p5 * 524288;
    p += mul_floor(p6, t, 6);
    p += mul_floor(p7, tsq, 24);
    p += mul_floor(p8, tcube, 23);
    p += mul_floor(u, p1, 4);
    p += mul_floor(u * p2, t, 29);
    p += mul_floor(u * p3, tsq, 48);
    p += mul_floor(u * p4, tcube, 45);
    p += mul_floor(uu, p9, 32);
    p += mul_floor(uu * p10, t, 48);
    p += mul_floor(uu, u * p11, 49);
    sat = 1'b0;
    tc = centi_round(t);
    if (tc < btpc_pkg::TEMP_MIN) begin tc = btpc_pkg::TEMP_MIN; sat = 1'b1; end
    if (tc > btpc_pkg::TEMP_MAX) begin tc = btpc_pkg::TEMP_MAX; sat = 1'b1; end
    pc = centi_round(p);
    if (pc < 0) begin pc = 0; sat = 1'b1; end
    if (pc > btpc_pkg::PRESS_MAX) begin pc = btpc_pkg::PRESS_MAX; sat = 1'b1; end
    r.temperature_centideg = tc[14:0];
    r.pressure_centipascal = pc[24:0];
    r.saturated_flag = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Input driver: the prediction is taken at the edge where the word is accepted.
  always @(posedge clk) begin
    logic nxt_valid;
    btpc_pkg::in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) expected_readings.push_back(compensate(in_data));
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (raw_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_data = raw_words.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Result monitor.
  always @(posedge clk) begin
    btpc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_data.temperature_centideg !== want.temperature_centideg)
          report_mismatch("temperature", out_data.temperature_centideg,
                          want.temperature_centideg);
        if (out_data.pressure_centipascal !== want.pressure_centipascal)
          report_mismatch("pressure", out_data.pressure_centipascal,
                          want.pressure_centipascal);
        if (out_data.saturated_flag !== want.saturated_flag)
          report_mismatch("saturated", out_data.saturated_flag, want.saturated_flag);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(btpc_pkg::cfg_reg_t idx, logic [btpc_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      btpc_pkg::REG_TEMP_COEFFS:    temp_cal = val[39:0];
      btpc_pkg::REG_PRESS_COEFFS_A: press_cal_a = val;
      btpc_pkg::REG_PRESS_COEFFS_B: press_cal_b = val;
      default:                      press_cal_c = val[31:0];
    endcase
  endtask

  task automatic drain();
    while (raw_words.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic btpc_pkg::in_t rand_word();
    btpc_pkg::in_t w;
    w.raw_temperature = 24'($urandom());
    w.raw_pressure = 24'($urandom());
    return w;
  endfunction

  initial begin
    btpc_pkg::in_t w;
    logic [23:0] edges[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = btpc_pkg::REG_TEMP_COEFFS;
    cfg_data = '0;
    temp_cal = '0;
    press_cal_a = '0;
    press_cal_b = '0;
    press_cal_c = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    edges[0] = 24'h000000; edges[1] = 24'hFFFFFF;
    edges[2] = 24'h800000; edges[3] = 24'h7FFFFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        0: begin
          write_reg(btpc_pkg::REG_TEMP_COEFFS, '0);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_A, '0);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_B, '0);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_C, '0);
        end
        1: begin
          write_reg(btpc_pkg::REG_TEMP_COEFFS, 48'h00FFFFFFFFFF);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_A, 48'hFFFFFFFFFFFF);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_B, 48'hFFFFFFFFFFFF);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_C, 48'h0000FFFFFFFF);
        end
        2: begin
          // Calibration in the range a real part ships with.
          write_reg(btpc_pkg::REG_TEMP_COEFFS, 48'h00F9_48AE_6C2B);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_A, 48'h03F2_F8E0_0540);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_B, 48'hF703_7590_4A38);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_C, 48'h0000_EBF6_1410);
        end
        3: begin
          write_reg(btpc_pkg::REG_TEMP_COEFFS, 48'h0080_FFFF_0000);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_A, 48'h8080_8000_8000);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_B, 48'h7F7F_FFFF_FFFF);
          write_reg(btpc_pkg::REG_PRESS_COEFFS_C, 48'h0000_7F7F_7FFF);
        end
        default: begin
          write_reg(btpc_pkg::REG_TEMP_COEFFS, rand48());
          write_reg(btpc_pkg::REG_PRESS_COEFFS_A, rand48());
          write_reg(btpc_pkg::REG_PRESS_COEFFS_B, rand48());
          write_reg(btpc_pkg::REG_PRESS_COEFFS_C, rand48());
        end
      endcase
      if (ph < 3) begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 2; j++) begin
            w.raw_temperature = edges[i];
            w.raw_pressure = edges[(i + j + 1) % 4];
            raw_words.push_back(w);
          end
      end
      for (int n = 0; n < 90; n++) begin
        w = rand_word();
        if (ph == 2 && n % 2 == 0) begin
          // Raw words near typical conversion results.
          w.raw_temperature = 24'(24'd8000000 + $urandom_range(1000000));
          w.raw_pressure = 24'(24'd6000000 + $urandom_range(2000000));
        end
        raw_words.push_back(w);
        // Hold the sender until the pipeline has fully emptied.
        if (ph == 3 && n == 45) drain();
      end
      drain();
    end

    if (error_count == 0) begin
      $display("baro_temp_pressure_compensation_top test passed");
    end else begin
      $display("baro_temp_pressure_compensation_top test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("baro_temp_pressure_compensation_top test failed");
    $finish;
  end
endmodule
